// File: rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Types, codes and constants shared by the rotary encoder click decoder.
// ----------------------------------------------------------------------------
package rcd_pkg;

	// Width of the internal step accumulator; the reported count is 16 bits.
	localparam int COUNT_WIDTH = 16;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 1'd1;

	localparam logic [15:0] LONG_PRESS_RESET    = 16'd1000;
	localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd300;

	localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
	localparam logic [1:0] FUNC_READ_COUNT = 2'd1;
	localparam logic [1:0] FUNC_READ_EVENT = 2'd2;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SINGLE = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG   = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic        data_level;
		logic        clock_level;
		logic        button_level;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic signed [15:0] step_count;
		logic [1:0]         button_event;
	} rsp_t;

	// Per-transaction control from the top level to the button machine.
	typedef struct packed {
		logic sample;
		logic read_event;
	} btn_ctrl_t;

endpackage

// File: rtl/rcd_button.sv
// ----------------------------------------------------------------------------
// rcd_button
// Four-phase button machine that times each press and records click events.
// ----------------------------------------------------------------------------
module rcd_button (
	input  logic              clk,
	input  logic              arst_n,
	input  rcd_pkg::btn_ctrl_t ctrl,
	input  logic              button_level,
	input  logic [31:0]       now_ms,
	input  logic [15:0]       long_press_ms,
	input  logic [15:0]       double_window_ms,
	output logic [1:0]        event_code
);
	import rcd_pkg::*;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PRESSED = 2'd1;
	localparam logic [1:0] PH_WAIT2   = 2'd2;
	localparam logic [1:0] PH_HOLD    = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [31:0] stamp_q, stamp_d;
	logic [1:0]  event_q, event_d;
	logic [31:0] elapsed;
	logic [31:0] long_ext, window_ext;

	assign long_ext   = {16'd0, long_press_ms};
	assign window_ext = {16'd0, double_window_ms};

	// The phases are visited in order, so one sample may pass through several.
	always_comb begin
		phase_d = phase_q;
		stamp_d = stamp_q;
		event_d = event_q;
		if (phase_d == PH_IDLE && !button_level) begin
			stamp_d = now_ms;
			phase_d = PH_PRESSED;
		end
		elapsed = now_ms - stamp_d;
		if (phase_d == PH_PRESSED) begin
			if (elapsed < long_ext && button_level) begin
				phase_d = PH_WAIT2;
			end else if (elapsed > long_ext) begin
				phase_d = PH_HOLD;
				event_d = EV_LONG;
			end
		end
		if (phase_d == PH_WAIT2) begin
			if (elapsed > window_ext) begin
				phase_d = PH_HOLD;
				event_d = EV_SINGLE;
			end else if (!button_level) begin
				phase_d = PH_HOLD;
				event_d = EV_DOUBLE;
			end
		end
		if (phase_d == PH_HOLD && button_level) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			stamp_q <= '0;
			event_q <= EV_NONE;
		end else if (ctrl.sample) begin
			phase_q <= phase_d;
			stamp_q <= stamp_d;
			event_q <= event_d;
		end else if (ctrl.read_event) begin
			event_q <= EV_NONE;
		end
	end

	assign event_code = event_q;

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.read_event && !ctrl.sample |=> event_q == EV_NONE)
		else $error("button event not cleared after read");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sample && phase_q == PH_IDLE && button_level |=> phase_q == PH_IDLE)
		else $error("button phase left idle without a press");

	a_event_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.sample && event_q == EV_NONE |=> event_q == EV_NONE)
		else $error("button event appeared without a sample");

endmodule

// File: rtl/rotary_encoder_click_decoder.sv
// ----------------------------------------------------------------------------
// rotary_encoder_click_decoder
// Quadrature encoder step counter with single, double and long press detect.
// ----------------------------------------------------------------------------
// Pipeline: a request is held in the input register once accepted, and its
// response is loaded into the response register when that register is free.
// Throughput: one transaction per cycle while rsp_stall does not hold a full
// output, a figure set by the state update of counter and button machine on each advance.
// Reset: arst_n clears valid flags, arming, counts and events; registers go to 1000/300.
module rotary_encoder_click_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  rcd_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output rcd_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rcd_pkg::*;

	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	logic        valid_s1;
	req_t        req_s1;
	logic        valid_s2;
	rsp_t        rsp_s2;
	logic        s2_free, advance;
	logic [15:0] long_press_q, double_window_q;

	logic                          data_armed_q, clock_armed_q;
	logic                          data_armed_d, clock_armed_d;
	logic signed [COUNT_WIDTH-1:0] acc_q, acc_mid, acc_d;
	logic                          data_fire, clock_fire;
	logic [1:0]                    event_code;
	btn_ctrl_t                     btn_ctrl;
	rsp_t                          rsp_d;

	function automatic logic signed [COUNT_WIDTH-1:0] step_sat(
		input logic signed [COUNT_WIDTH-1:0] v,
		input logic                          en,
		input logic                          up
	);
		logic signed [COUNT_WIDTH-1:0] r;
		r = v;
		if (en) begin
			if (up) begin
				if (v != CNT_MAX) r = v + CNT_ONE;
			end else begin
				if (v != CNT_MIN) r = v - CNT_ONE;
			end
		end
		return r;
	endfunction

	assign s2_free   = !valid_s2 || !rsp_stall;
	assign advance   = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= LONG_PRESS_RESET;
			double_window_q <= DOUBLE_WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LONG_PRESS:    long_press_q <= cfg_data;
				REG_DOUBLE_WINDOW: double_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req;
	end

	// Data edge first; the clock edge then sees the updated data arming.
	always_comb begin
		data_fire     = data_armed_q && !req_s1.data_level;
		data_armed_d  = data_fire ? 1'b0 : data_armed_q;
		acc_mid       = step_sat(acc_q, data_fire, !clock_armed_q);
		clock_fire    = clock_armed_q && !req_s1.clock_level;
		clock_armed_d = clock_fire ? 1'b0 : clock_armed_q;
		acc_d         = step_sat(acc_mid, clock_fire, data_armed_d);
		if (req_s1.data_level && req_s1.clock_level) begin
			data_armed_d  = 1'b1;
			clock_armed_d = 1'b1;
		end
	end

	assign btn_ctrl.sample     = advance && req_s1.func == FUNC_SAMPLE;
	assign btn_ctrl.read_event = advance && req_s1.func == FUNC_READ_EVENT;

	rcd_button u_button (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (btn_ctrl),
		.button_level     (req_s1.button_level),
		.now_ms           (req_s1.now_ms),
		.long_press_ms    (long_press_q),
		.double_window_ms (double_window_q),
		.event_code       (event_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_armed_q  <= 1'b0;
			clock_armed_q <= 1'b0;
			acc_q         <= '0;
		end else if (advance) begin
			case (req_s1.func)
				FUNC_SAMPLE: begin
					data_armed_q  <= data_armed_d;
					clock_armed_q <= clock_armed_d;
					acc_q         <= acc_d;
				end
				FUNC_READ_COUNT: acc_q <= '0;
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp_d = '0;
		case (req_s1.func)
			FUNC_READ_COUNT: rsp_d.step_count = 16'(acc_q);
			FUNC_READ_EVENT: rsp_d.button_event = event_code;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_s2 <= rsp_d;
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && rsp_stall)
		else $error("request stalled with room in the pipeline");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.func == FUNC_READ_COUNT |=> acc_q == '0)
		else $error("step count not cleared after read");

	a_sample_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.func == FUNC_SAMPLE |=> rsp_valid && rsp == '0)
		else $error("sample transaction gave a nonzero response");

	a_count_rsp_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.func != FUNC_READ_COUNT |=> rsp.step_count == '0)
		else $error("step count reported on a non-count transaction");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder click decoder testbench
// Drives pin samples and read requests through the stall handshake, and
// predicts every response with an independent model of the step counter and
// button machine. The stimulus covers directed edge cases, random encoder
// turns and timed button presses under several register settings. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import rcd_pkg::*;

	// Function code that the block ignores; it answers with an all-zero response.
	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef enum logic [1:0] {
		BTN_IDLE,
		BTN_DOWN,
		BTN_WAIT_SECOND,
		BTN_WAIT_RELEASE
	} btn_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rotary_encoder_click_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted decoder state and register copies.
	logic armed_data = 1'b0;
	logic armed_clock = 1'b0;
	int steps = 0;
	btn_phase_t phase = BTN_IDLE;
	logic [31:0] press_ms = '0;
	logic [1:0] event_pending = EV_NONE;
	logic [15:0] long_ms = LONG_PRESS_RESET;
	logic [15:0] window_ms = DOUBLE_WINDOW_RESET;

	req_t pending_req[$];
	rsp_t expected_rsp[$];
	rsp_t want;
	rsp_t predicted;
	logic req_taken = 1'b0;
	int mismatches = 0;
	int responses_seen = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// Stimulus generator state.
	logic [31:0] gen_now = '0;
	int gen_pos = 0;
	logic gen_d = 1'b1;
	logic gen_c = 1'b1;
	logic gen_b = 1'b1;
	int gen_count = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	task automatic bump_steps(input int dir);
		longint top;
		longint bottom;
		longint v;
		top = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
		bottom = -top - 1;
		v = longint'(steps) + longint'(dir);
		if (v > top)
			v = top;
		if (v < bottom)
			v = bottom;
		steps = int'(v);
	endtask

	task automatic advance_decoder(input req_t r, output rsp_t o);
		logic [31:0] elapsed;
		o = '0;
		case (r.func)
			FUNC_SAMPLE: begin
				// The clock edge sees the data arming as already updated by the data edge.
				if (armed_data && !r.data_level) begin
					armed_data = 1'b0;
					bump_steps(armed_clock ? -1 : 1);
				end
				if (armed_clock && !r.clock_level) begin
					armed_clock = 1'b0;
					bump_steps(armed_data ? 1 : -1);
				end
				if (r.data_level && r.clock_level) begin
					armed_data = 1'b1;
					armed_clock = 1'b1;
				end
				// One sample may walk through several button phases.
				if (phase == BTN_IDLE && !r.button_level) begin
					press_ms = r.now_ms;
					phase = BTN_DOWN;
				end
				elapsed = r.now_ms - press_ms;
				if (phase == BTN_DOWN) begin
					if (elapsed < {16'd0, long_ms} && r.button_level) begin
						phase = BTN_WAIT_SECOND;
					end else if (elapsed > {16'd0, long_ms}) begin
						phase = BTN_WAIT_RELEASE;
						event_pending = EV_LONG;
					end
				end
				if (phase == BTN_WAIT_SECOND) begin
					if (elapsed > {16'd0, window_ms}) begin
						phase = BTN_WAIT_RELEASE;
						event_pending = EV_SINGLE;
					end else if (!r.button_level) begin
						phase = BTN_WAIT_RELEASE;
						event_pending = EV_DOUBLE;
					end
				end
				if (phase == BTN_WAIT_RELEASE && r.button_level)
					phase = BTN_IDLE;
			end
			FUNC_READ_COUNT: begin
				o.step_count = steps[15:0];
				steps = 0;
			end
			FUNC_READ_EVENT: begin
				o.button_event = event_pending;
				event_pending = EV_NONE;
			end
			default: ;
		endcase
	endtask

	// Checks responses against the oldest prediction and predicts each accepted request.
	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				responses_seen++;
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("response with nothing outstanding: %0d %0d",
						rsp.step_count, rsp.button_event));
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.step_count !== want.step_count)
						report_mismatch($sformatf("step_count %0d, expected %0d",
							rsp.step_count, want.step_count));
					if (rsp.button_event !== want.button_event)
						report_mismatch($sformatf("button_event %0d, expected %0d",
							rsp.button_event, want.button_event));
				end
			end
			if (req_valid && !req_stall) begin
				advance_decoder(req, predicted);
				expected_rsp.push_back(predicted);
			end
		end
	end

	// Request driver: a stalled transaction is held unchanged until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (send_gap == 0 && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
				send_gap = $urandom_range(1, 16);
			if (send_gap != 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side: random stall bursts, plus one long hold-off that fills the block.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!hold_done && responses_seen >= 100) begin
			hold_done = 1'b1;
			hold_left = 299;
			rsp_stall <= 1'b1;
		end else begin
			if (recv_gap == 0 && recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
				recv_gap = $urandom_range(1, 16);
			if (recv_gap != 0) begin
				recv_gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic push_item(input logic [1:0] func, input logic d, input logic c,
		input logic b, input logic [31:0] now);
		req_t r;
		r.func = func;
		r.data_level = d;
		r.clock_level = c;
		r.button_level = b;
		r.now_ms = now;
		pending_req.push_back(r);
		if (func != FUNC_NOP)
			gen_count++;
	endtask

	task automatic emit(input logic [31:0] t);
		push_item(FUNC_SAMPLE, gen_d, gen_c, gen_b, t);
		gen_now = t;
	endtask

	// Walks the quadrature code 11, 01, 00, 10 one way or the other, with some contact bounce.
	task automatic spin_encoder(input int detents, input logic up);
		int i;
		for (i = 0; i < detents * 4; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				gen_pos = (gen_pos + (up ? 3 : 1)) % 4;
				gen_d = (gen_pos == 0 || gen_pos == 3);
				gen_c = (gen_pos == 0 || gen_pos == 1);
				emit(gen_now + $urandom_range(1, 4));
			end
			gen_pos = (gen_pos + (up ? 1 : 3)) % 4;
			gen_d = (gen_pos == 0 || gen_pos == 3);
			gen_c = (gen_pos == 0 || gen_pos == 1);
			emit(gen_now + $urandom_range(1, 4));
		end
	endtask

	// Offsets from a press, aimed at both sides of and exactly on each limit.
	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return {16'd0, long_ms} - 32'd1;
			1: return {16'd0, long_ms};
			2: return {16'd0, long_ms} + 32'd1;
			3: return {16'd0, window_ms} - 32'd1;
			4: return {16'd0, window_ms};
			5: return {16'd0, window_ms} + 32'd1;
			6: return $urandom;
			7: return $urandom_range(0, 32'(long_ms) + 2);
			default: return $urandom_range(0, 32'(window_ms) + 2);
		endcase
	endfunction

	task automatic press_episode();
		logic [31:0] press_t;
		int k;
		int i;
		press_t = gen_now + $urandom_range(1, 40);
		gen_b = 1'b0;
		emit(press_t);
		k = $urandom_range(1, 4);
		for (i = 0; i < k; i++) begin
			if ($urandom_range(0, 99) < 60)
				gen_b = !gen_b;
			emit(press_t + pick_offset());
		end
		gen_b = 1'b1;
		emit(press_t + pick_offset());
		if ($urandom_range(0, 1) == 1)
			emit(gen_now + $urandom_range(1, 400));
	endtask

	task automatic random_episode();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			spin_encoder($urandom_range(1, 6), 1'($urandom_range(0, 1)));
		else if (pick < 70)
			press_episode();
		else if (pick < 85)
			push_item($urandom_range(0, 1) ? FUNC_READ_COUNT : FUNC_READ_EVENT,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom);
		else
			push_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic wait_drained();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_LONG_PRESS: long_ms = value;
			REG_DOUBLE_WINDOW: window_ms = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] lp, input logic [15:0] dw,
		input int spct, input int rpct, input int n);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_DOUBLE_WINDOW, dw);
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		gen_now = $urandom;
		gen_count = 0;
		while (gen_count < n)
			random_episode();
		wait_drained();
	endtask

	initial begin
		logic [31:0] t;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_LONG_PRESS, LONG_PRESS_RESET);
		write_reg(REG_DOUBLE_WINDOW, DOUBLE_WINDOW_RESET);

		// Directed part under the reset settings.
		push_item(FUNC_NOP, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		push_item(FUNC_READ_COUNT, 1'b0, 1'b0, 1'b0, 32'd0);
		push_item(FUNC_READ_EVENT, 1'b0, 1'b0, 1'b0, 32'd0);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0);
		push_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd1);
		push_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd2);
		push_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd3);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd4);
		push_item(FUNC_READ_COUNT, 1'b1, 1'b1, 1'b1, 32'd5);
		push_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd6);
		push_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd7);
		push_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd8);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd9);
		push_item(FUNC_READ_COUNT, 1'b1, 1'b1, 1'b1, 32'd10);
		// Long press across the timestamp wrap; released exactly at the limit first.
		t = 32'hFFFF_FF00;
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, t);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, t + 32'd1000);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, t + 32'd1001);
		push_item(FUNC_READ_EVENT, 1'b1, 1'b1, 1'b1, 32'd2000);
		// Double click with the second press exactly at the window edge.
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd5000);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd5050);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd5300);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd5400);
		push_item(FUNC_READ_EVENT, 1'b1, 1'b1, 1'b1, 32'd5500);
		// Single click: the window runs out one millisecond after its edge.
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd6000);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd6100);
		push_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd6301);
		push_item(FUNC_READ_EVENT, 1'b1, 1'b1, 1'b1, 32'd6400);
		wait_drained();

		run_phase(LONG_PRESS_RESET, DOUBLE_WINDOW_RESET, 20, 20, 240);
		run_phase(16'd0, 16'd0, 0, 0, 240);
		run_phase(16'hFFFF, 16'hFFFF, 30, 10, 240);
		run_phase(16'd25, 16'd60, 10, 30, 240);
		run_phase(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 25, 25, 240);
		run_phase(16'd70, 16'd5, 15, 15, 240);

		// Closing stretch without any idling.
		run_phase(16'd40, 16'd120, 0, 0, 150);

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
